[hw/rtl/aesbc_pkg.sv]
// ----------------------------------------------------------------------------
// aesbc_pkg
// Shared types, codes, S-box tables and round functions for the AES block core.
// ----------------------------------------------------------------------------
package aesbc_pkg;

    localparam int NUM_KEYS   = 15;
    localparam int NUM_STAGES = 15;
    localparam int MIN_ROUNDS = 10;
    localparam int MAX_ROUNDS = NUM_KEYS - 1;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ENC  = 2'd1,
        CMD_DEC  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic active;
        logic sub;
        logic mix;
    } stage_ctrl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(r+4*((c+r)%4)) +: 8] = INV_SBOX[s[8*(r+4*c) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a [4];
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j] = s[8*(4*c+j) +: 8];
            end
            for (int r = 0; r < 4; r++) begin
                t[8*(4*c+r) +: 8] = xt(a[r]) ^ xt(a[(r+1)%4]) ^ a[(r+1)%4]
                                  ^ a[(r+2)%4] ^ a[(r+3)%4];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a  [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]  = s[8*(4*c+j) +: 8];
                x2[j] = xt(a[j]);
                x4[j] = xt(x2[j]);
                x8[j] = xt(x4[j]);
            end
            for (int r = 0; r < 4; r++) begin
                t[8*(4*c+r) +: 8] =
                    (x8[r] ^ x4[r] ^ x2[r])
                  ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                  ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                  ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
        return t;
    endfunction

endpackage

[hw/rtl/aesbc_keys.sv]
// ----------------------------------------------------------------------------
// aesbc_keys
// Round key store with a fixed encrypt key tap per pipeline stage and a decrypt tap chosen by the round count.
// ----------------------------------------------------------------------------
module aesbc_keys (
    input  logic         clk,
    input  logic         wr_en,
    input  logic [3:0]   wr_idx,
    input  logic [127:0] wr_data,
    input  logic [3:0]   nr,
    output logic [127:0] enc_key [aesbc_pkg::NUM_STAGES],
    output logic [127:0] dec_key [aesbc_pkg::NUM_STAGES]
);

    logic [127:0] key_reg [aesbc_pkg::NUM_KEYS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg[wr_idx] <= wr_data;
        end
    end

    always_comb
    begin
        for (int s = 0; s < aesbc_pkg::NUM_STAGES; s++)
        begin
            enc_key[s] = key_reg[s];
            dec_key[s] = '0;
            for (int k = aesbc_pkg::MIN_ROUNDS; k <= aesbc_pkg::MAX_ROUNDS; k++)
            begin
                if (nr == 4'(k) && k >= s)
                begin
                    dec_key[s] = key_reg[k - s];
                end
            end
        end
    end

endmodule

[hw/rtl/aesbc_round.sv]
// ----------------------------------------------------------------------------
// aesbc_round
// One registered cipher round stage with valid/ready flow control.
// ----------------------------------------------------------------------------
module aesbc_round (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [127:0]           in_state,
    input  logic                   in_dec,
    input  aesbc_pkg::stage_ctrl_t ctrl,
    input  logic [127:0]           key,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [127:0]           out_state,
    output logic                   out_dec
);

    logic         valid_reg;
    logic [127:0] state_reg;
    logic         dec_reg;
    logic [127:0] sub_v;
    logic [127:0] enc_v;
    logic [127:0] dec_v;
    logic [127:0] state_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sub_v = in_state;
        if (ctrl.sub)
        begin
            sub_v = in_dec ? aesbc_pkg::inv_sub_shift(in_state)
                           : aesbc_pkg::sub_shift(in_state);
        end
        enc_v = (ctrl.mix ? aesbc_pkg::mix(sub_v) : sub_v) ^ key;
        dec_v = ctrl.mix ? aesbc_pkg::inv_mix(sub_v ^ key) : (sub_v ^ key);
        if (!ctrl.active)
        begin
            state_next = in_state;
        end
        else
        begin
            state_next = in_dec ? dec_v : enc_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            state_reg <= state_next;
            dec_reg   <= in_dec;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_dec   = dec_reg;

endmodule

[hw/rtl/aes_block_encrypt_decrypt.sv]
// ----------------------------------------------------------------------------
// aes_block_encrypt_decrypt
// AES-128/192/256 block encrypt/decrypt core with a loaded expanded key.
// ----------------------------------------------------------------------------
// A 15-stage pipeline, key whitening then one round per stage, carries a block
// from acceptance to result, with shorter key sizes passing the unused stages
// unchanged. One encrypt or decrypt transaction enters per cycle while the
// pipeline is not stalled by the receiver. A key load transaction waits until
// the pipeline holds no block, then writes its round key at once. round_count
// must be written only while the core is idle.
module aes_block_encrypt_decrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [3:0]  key_index,
    input  logic [63:0] data_lo,
    input  logic [63:0] data_hi,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_lo,
    output logic [63:0] result_hi
);

    localparam int NS = aesbc_pkg::NUM_STAGES;

    logic [3:0]   round_count_reg;
    logic [3:0]   nr;
    logic         is_load;
    logic         is_block;
    logic         empty;
    logic         key_wr;
    logic [127:0] enc_key [NS];
    logic [127:0] dec_key [NS];

    logic                   st_in_valid [NS];
    logic                   st_in_ready [NS];
    logic [127:0]           st_in_state [NS];
    logic                   st_in_dec   [NS];
    aesbc_pkg::stage_ctrl_t st_ctrl     [NS];
    logic [127:0]           st_key      [NS];
    logic                   st_valid    [NS];
    logic                   st_ready    [NS];
    logic [127:0]           st_state    [NS];
    logic                   st_dec      [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= 4'd10;
        end
        else if (cfg_we)
        begin
            round_count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (round_count_reg < 4'(aesbc_pkg::MIN_ROUNDS))
        begin
            nr = 4'(aesbc_pkg::MIN_ROUNDS);
        end
        else if (round_count_reg > 4'(aesbc_pkg::MAX_ROUNDS))
        begin
            nr = 4'(aesbc_pkg::MAX_ROUNDS);
        end
        else
        begin
            nr = round_count_reg;
        end
    end

    always_comb
    begin
        empty = 1'b1;
        for (int s = 0; s < NS; s++)
        begin
            if (st_valid[s])
            begin
                empty = 1'b0;
            end
        end
    end

    assign is_load  = (cmd == aesbc_pkg::CMD_LOAD);
    assign is_block = (cmd == aesbc_pkg::CMD_ENC) || (cmd == aesbc_pkg::CMD_DEC);
    assign in_ready = st_in_ready[0] && (!is_load || empty);
    assign key_wr   = in_valid && in_ready && is_load
                      && (key_index < 4'(aesbc_pkg::NUM_KEYS));

    aesbc_keys u_keys (
        .clk     (clk),
        .wr_en   (key_wr),
        .wr_idx  (key_index),
        .wr_data ({data_hi, data_lo}),
        .nr      (nr),
        .enc_key (enc_key),
        .dec_key (dec_key)
    );

    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                st_in_valid[s] = in_valid && is_block && in_ready;
                st_in_state[s] = {data_hi, data_lo};
                st_in_dec[s]   = (cmd == aesbc_pkg::CMD_DEC);
            end
            else
            begin
                st_in_valid[s] = st_valid[s-1];
                st_in_state[s] = st_state[s-1];
                st_in_dec[s]   = st_dec[s-1];
            end
            st_ctrl[s].active = (4'(s) <= nr);
            st_ctrl[s].sub    = (s != 0);
            st_ctrl[s].mix    = (s != 0) && (4'(s) < nr);
            st_key[s]         = st_in_dec[s] ? dec_key[s] : enc_key[s];
            st_ready[s]       = (s == NS - 1) ? out_ready : st_in_ready[(s + 1) % NS];
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        aesbc_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_in_valid[g]),
            .in_ready  (st_in_ready[g]),
            .in_state  (st_in_state[g]),
            .in_dec    (st_in_dec[g]),
            .ctrl      (st_ctrl[g]),
            .key       (st_key[g]),
            .out_valid (st_valid[g]),
            .out_ready (st_ready[g]),
            .out_state (st_state[g]),
            .out_dec   (st_dec[g])
        );
    end

    assign out_valid = st_valid[NS-1];
    assign result_lo = st_state[NS-1][63:0];
    assign result_hi = st_state[NS-1][127:64];

endmodule

[hw/rtl/aesbc_checker.sv]
// ----------------------------------------------------------------------------
// aesbc_checker
// Port-level checks for the AES block core, bound to the top level.
// ----------------------------------------------------------------------------
module aesbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  cmd,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_lo,
    input logic [63:0] result_hi
);

    logic load_acc;

    assign load_acc = in_valid && in_ready && (cmd == aesbc_pkg::CMD_LOAD);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_lo) && $stable(result_hi))
        else $error("stalled result changed or dropped");

    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |-> !out_valid)
        else $error("key load taken with a result pending");

    a_load_drain: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |=> !out_valid)
        else $error("result appeared right after a key load");

endmodule

bind aes_block_encrypt_decrypt aesbc_checker u_aesbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_lo (result_lo),
    .result_hi (result_hi)
);

[tb/sv/tb_aes_block_encrypt_decrypt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes_block_encrypt_decrypt
// Self-checking bench for the AES block core: round keys are loaded, then
// encrypt, decrypt and further key load transactions run against a bench-side
// cipher model over several round counts, with random stalls on both channels
// and one long receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_aes_block_encrypt_decrypt;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS = 290;

    typedef struct packed {
        aesbc_pkg::cmd_t cmd;
        logic [3:0]      idx;
        logic [63:0]     lo;
        logic [63:0]     hi;
    } xact_t;

    localparam int NUM_ROWS = 23;
    localparam xact_t DIRECTED [NUM_ROWS] = '{
        '{aesbc_pkg::CMD_LOAD, 4'd0,  64'h0, 64'h0},
        '{aesbc_pkg::CMD_LOAD, 4'd1,  64'h0706050403020100, 64'h0f0e0d0c0b0a0908},
        '{aesbc_pkg::CMD_LOAD, 4'd2,  64'h1111111111111111, 64'h2222222222222222},
        '{aesbc_pkg::CMD_LOAD, 4'd3,  64'h3333333333333333, 64'h4444444444444444},
        '{aesbc_pkg::CMD_LOAD, 4'd4,  64'h5555555555555555, 64'haaaaaaaaaaaaaaaa},
        '{aesbc_pkg::CMD_LOAD, 4'd5,  64'h0123456789abcdef, 64'hfedcba9876543210},
        '{aesbc_pkg::CMD_LOAD, 4'd6,  64'h8000000000000001, 64'h8000000000000001},
        '{aesbc_pkg::CMD_LOAD, 4'd7,  64'h6666666666666666, 64'h7777777777777777},
        '{aesbc_pkg::CMD_LOAD, 4'd8,  64'h8888888888888888, 64'h9999999999999999},
        '{aesbc_pkg::CMD_LOAD, 4'd9,  64'hbbbbbbbbbbbbbbbb, 64'hcccccccccccccccc},
        '{aesbc_pkg::CMD_LOAD, 4'd10, 64'hdddddddddddddddd, 64'heeeeeeeeeeeeeeee},
        '{aesbc_pkg::CMD_LOAD, 4'd11, 64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00},
        '{aesbc_pkg::CMD_LOAD, 4'd12, 64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0},
        '{aesbc_pkg::CMD_LOAD, 4'd13, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c},
        '{aesbc_pkg::CMD_LOAD, 4'd14, 64'hffffffffffffffff, 64'hffffffffffffffff},
        '{aesbc_pkg::CMD_LOAD, 4'd15, 64'hdeadbeefdeadbeef, 64'hdeadbeefdeadbeef},
        '{aesbc_pkg::CMD_NONE, 4'd15, 64'hffffffffffffffff, 64'hffffffffffffffff},
        '{aesbc_pkg::CMD_ENC,  4'd0,  64'h0, 64'h0},
        '{aesbc_pkg::CMD_ENC,  4'd15, 64'hffffffffffffffff, 64'hffffffffffffffff},
        '{aesbc_pkg::CMD_DEC,  4'd0,  64'h0, 64'h0},
        '{aesbc_pkg::CMD_DEC,  4'd15, 64'hffffffffffffffff, 64'hffffffffffffffff},
        '{aesbc_pkg::CMD_ENC,  4'd7,  64'h7766554433221100, 64'hffeeddccbbaa9988},
        '{aesbc_pkg::CMD_DEC,  4'd7,  64'h7766554433221100, 64'hffeeddccbbaa9988}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [3:0]  key_index;
    logic [63:0] data_lo;
    logic [63:0] data_hi;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_lo;
    logic [63:0] result_hi;

    logic [7:0]   sbox_tab     [256];
    logic [7:0]   inv_sbox_tab [256];
    logic [63:0]  key_lo [aesbc_pkg::NUM_KEYS];
    logic [63:0]  key_hi [aesbc_pkg::NUM_KEYS];
    logic [3:0]   rounds_reg;
    logic [127:0] pending_blocks [$];
    int           fail_count = 0;
    int           sent_items = 0;
    int           results_seen = 0;
    int           idle_cycles = 0;

    aes_block_encrypt_decrypt dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key_index (key_index),
        .data_lo   (data_lo),
        .data_hi   (data_hi),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result_lo (result_lo),
        .result_hi (result_hi)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [127:0] byte_sub_shift(input logic [127:0] s, input bit inv);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (inv)
                    t[8*(r+4*((c+r)%4)) +: 8] = inv_sbox_tab[s[8*(r+4*c) +: 8]];
                else
                    t[8*(r+4*c) +: 8] = sbox_tab[s[8*(r+4*((c+r)%4)) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] column_mix(input logic [127:0] s, input bit inv);
        logic [127:0] t;
        logic [7:0]   coef [4];
        logic [7:0]   o;
        if (inv)
            coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o = 8'h00;
                for (int j = 0; j < 4; j++)
                    o ^= gf_mul(s[8*(4*c+j) +: 8], coef[(j-r+4)%4]);
                t[8*(4*c+r) +: 8] = o;
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] cipher_block(input aesbc_pkg::cmd_t op,
                                                  input logic [127:0] blk);
        int nr;
        logic [127:0] s;
        nr = rounds_reg;
        if (nr < aesbc_pkg::MIN_ROUNDS)
            nr = aesbc_pkg::MIN_ROUNDS;
        if (nr > aesbc_pkg::MAX_ROUNDS)
            nr = aesbc_pkg::MAX_ROUNDS;
        s = blk;
        if (op == aesbc_pkg::CMD_ENC)
        begin
            s ^= {key_hi[0], key_lo[0]};
            for (int r = 1; r < nr; r++)
                s = column_mix(byte_sub_shift(s, 1'b0), 1'b0) ^ {key_hi[r], key_lo[r]};
            s = byte_sub_shift(s, 1'b0) ^ {key_hi[nr], key_lo[nr]};
        end
        else
        begin
            s ^= {key_hi[nr], key_lo[nr]};
            for (int r = nr - 1; r >= 1; r--)
                s = column_mix(byte_sub_shift(s, 1'b1) ^ {key_hi[r], key_lo[r]}, 1'b1);
            s = byte_sub_shift(s, 1'b1) ^ {key_hi[0], key_lo[0]};
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && in_valid && in_ready)
        begin
            case (aesbc_pkg::cmd_t'(cmd)) inside
                aesbc_pkg::CMD_LOAD:
                    if (key_index < aesbc_pkg::NUM_KEYS)
                    begin
                        key_lo[key_index] = data_lo;
                        key_hi[key_index] = data_hi;
                    end
                aesbc_pkg::CMD_ENC, aesbc_pkg::CMD_DEC:
                    pending_blocks.push_back(cipher_block(aesbc_pkg::cmd_t'(cmd),
                                                          {data_hi, data_lo}));
                default: ;
            endcase
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_blocks.size() == 0)
            begin
                $display("unexpected result %h %h", result_hi, result_lo);
                fail_count++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (result_lo !== want[63:0])
                    report_mismatch("result_lo", result_lo, want[63:0]);
                if (result_hi !== want[127:64])
                    report_mismatch("result_hi", result_hi, want[127:64]);
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("aes_block_encrypt_decrypt verification failed");
            $finish;
        end
    end

    function automatic bit calm_window();
        return sent_items >= 1200 && sent_items < 1500;
    endfunction

    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 400)
            begin
                held = 1'b1;
                out_ready = 1'b0;
                repeat (300) @(negedge clk);
            end
            out_ready = calm_window() || ($urandom % 100 >= 28);
        end
    end

    task automatic send(input xact_t x);
        while (!calm_window() && $urandom % 100 < 28)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd       = x.cmd;
        key_index = x.idx;
        data_lo   = x.lo;
        data_hi   = x.hi;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sent_items++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_rounds(input logic [3:0] value);
        while (pending_blocks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wdata  = value;
        cfg_we     = 1'b1;
        @(negedge clk);
        rounds_reg = value;
        cfg_we     = 1'b0;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom % 8)
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic xact_t rand_xact();
        xact_t x;
        int pick;
        pick  = $urandom % 100;
        x.lo  = rand_word();
        x.hi  = rand_word();
        x.idx = 4'($urandom_range(0, 15));
        if (pick < 6)
        begin
            x.cmd = aesbc_pkg::CMD_LOAD;
            x.idx = 4'($urandom_range(0, aesbc_pkg::NUM_KEYS - 1));
        end
        else if (pick < 8)
        begin
            x.cmd = aesbc_pkg::CMD_LOAD;
            x.idx = 4'd15;
        end
        else if (pick < 10)
            x.cmd = aesbc_pkg::CMD_NONE;
        else
            x.cmd = ($urandom % 2) ? aesbc_pkg::CMD_ENC : aesbc_pkg::CMD_DEC;
        return x;
    endfunction

    initial
    begin
        logic [3:0] settings [7];
        logic [7:0] inv;
        settings     = '{4'd10, 4'd12, 4'd14, 4'd0, 4'd15, 4'd11, 4'd13};
        rounds_reg   = 4'd10;
        for (int k = 0; k < aesbc_pkg::NUM_KEYS; k++)
        begin
            key_lo[k] = '0;
            key_hi[k] = '0;
        end
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(8'(x), 8'(y)) == 8'h01)
                    inv = 8'(y);
            sbox_tab[x] = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3)
                        ^ rol8(inv, 4) ^ 8'h63;
            inv_sbox_tab[sbox_tab[x]] = 8'(x);
        end
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 4'd0;
        in_valid  = 1'b0;
        cmd       = aesbc_pkg::CMD_NONE;
        key_index = 4'd0;
        data_lo   = '0;
        data_hi   = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int i = 0; i < NUM_ROWS; i++)
            send(DIRECTED[i]);
        for (int p = 0; p < 7; p++)
        begin
            write_rounds(settings[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send(rand_xact());
        end
        while (pending_blocks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("aes_block_encrypt_decrypt verification clean");
        else
            $display("aes_block_encrypt_decrypt verification failed");
        $finish;
    end

endmodule
